>>> hw/rtl/imm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Integer matrix multiply package
// Shared codes, register indexes and the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package imm_pkg;

  localparam logic [1:0] KIND_LOAD_A  = 2'd0;
  localparam logic [1:0] KIND_LOAD_B  = 2'd1;
  localparam logic [1:0] KIND_COMPUTE = 2'd2;

  localparam logic [1:0] REG_A_ROWS  = 2'd0;
  localparam logic [1:0] REG_INNER   = 2'd1;
  localparam logic [1:0] REG_B_COLS  = 2'd2;

  localparam logic [3:0] DIM_RESET = 4'd8;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic start;
    logic issue;
    logic emit;
  } imm_cmd_t;

  typedef struct packed {
    logic in_range;
    logic last_k;
    logic last_elem;
    logic acc_done;
    logic out_free;
  } imm_status_t;

endpackage
`default_nettype wire

>>> hw/rtl/imm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Integer matrix multiply controller
// Decodes requests and sequences the dot product of every result element.
// ----------------------------------------------------------------------------
module imm_ctrl
  import imm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  kind,
  input  wire imm_status_t status,
  output imm_cmd_t         cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_LOAD_A: cmd.load_a = status.in_range;
            KIND_LOAD_B: cmd.load_b = status.in_range;
            KIND_COMPUTE: begin
              cmd.start  = 1'b1;
              state_next = ST_ISSUE;
            end
            default: ;
          endcase
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        if (status.last_k) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (status.acc_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = status.last_elem ? ST_IDLE : ST_ISSUE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/imm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Integer matrix multiply datapath
// Element stores, index counters, read, multiply and accumulate stages,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module imm_datapath
  import imm_pkg::*;
#(
  parameter int MAX_DIM = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire imm_cmd_t           cmd,
  output imm_status_t             status,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [3:0]         cfg_data,
  input  wire logic [2:0]         row_index,
  input  wire logic [2:0]         col_index,
  input  wire logic signed [31:0] elem_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_row,
  output logic [2:0]              out_col,
  output logic signed [31:0]      product_value,
  output logic                    last
);

  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  function automatic logic [IDX_W-1:0] last_of(input logic [3:0] v);
    logic [3:0] e;
    begin
      if (v == 4'd0) begin
        e = 4'd0;
      end else if (v > 4'(MAX_DIM)) begin
        e = 4'(MAX_DIM - 1);
      end else begin
        e = v - 4'd1;
      end
      return IDX_W'(e);
    end
  endfunction

  logic [31:0]       mem_a [DEPTH];
  logic [31:0]       mem_b [DEPTH];
  logic [3:0]        a_row_count;
  logic [3:0]        inner_count;
  logic [3:0]        b_col_count;
  logic [IDX_W-1:0]  rows_last;
  logic [IDX_W-1:0]  inner_last;
  logic [IDX_W-1:0]  cols_last;
  logic [IDX_W-1:0]  i_cnt;
  logic [IDX_W-1:0]  j_cnt;
  logic [IDX_W-1:0]  k_cnt;
  logic [ADDR_W-1:0] load_addr;
  logic [ADDR_W-1:0] addr_a;
  logic [ADDR_W-1:0] addr_b;
  logic [31:0]       rd_a;
  logic [31:0]       rd_b;
  logic [31:0]       prod;
  logic [31:0]       acc;
  logic              v1;
  logic              v2;
  logic              lk1;
  logic              lk2;
  logic              done;

  assign load_addr = ADDR_W'(ADDR_W'(row_index) * ADDR_W'(MAX_DIM) + ADDR_W'(col_index));
  assign addr_a    = ADDR_W'(ADDR_W'(i_cnt) * ADDR_W'(MAX_DIM) + ADDR_W'(k_cnt));
  assign addr_b    = ADDR_W'(ADDR_W'(k_cnt) * ADDR_W'(MAX_DIM) + ADDR_W'(j_cnt));

  assign status.in_range  = (4'(row_index) < 4'(MAX_DIM)) && (4'(col_index) < 4'(MAX_DIM));
  assign status.last_k    = (k_cnt == inner_last);
  assign status.last_elem = (i_cnt == rows_last) && (j_cnt == cols_last);
  assign status.acc_done  = done;
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_a) begin
      mem_a[load_addr] <= elem_value;
    end
    if (cmd.load_b) begin
      mem_b[load_addr] <= elem_value;
    end
    if (cmd.issue) begin
      rd_a <= mem_a[addr_a];
      rd_b <= mem_b[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_row_count <= DIM_RESET;
      inner_count <= DIM_RESET;
      b_col_count <= DIM_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_A_ROWS: a_row_count <= cfg_data;
        REG_INNER:  inner_count <= cfg_data;
        REG_B_COLS: b_col_count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rows_last  <= last_of(a_row_count);
      inner_last <= last_of(inner_count);
      cols_last  <= last_of(b_col_count);
      i_cnt      <= '0;
      j_cnt      <= '0;
      k_cnt      <= '0;
    end else begin
      if (cmd.issue) begin
        k_cnt <= status.last_k ? '0 : k_cnt + 1'b1;
      end
      if (cmd.emit) begin
        if (j_cnt == cols_last) begin
          j_cnt <= '0;
          i_cnt <= i_cnt + 1'b1;
        end else begin
          j_cnt <= j_cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= cmd.issue;
      v2   <= v1;
      done <= v2 && lk2;
    end
  end

  always_ff @(posedge clk) begin
    lk1 <= status.last_k;
    lk2 <= lk1;
    if (v1) begin
      prod <= rd_a * rd_b;
    end
    if (cmd.start || cmd.emit) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_row       <= 3'(i_cnt);
      out_col       <= 3'(j_cnt);
      product_value <= acc;
      last          <= status.last_elem;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/integer_matrix_multiply.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Integer matrix multiply
// Signed 32-bit matrix product C = A x B over stored element matrices.
// ----------------------------------------------------------------------------
// Usage:
// Input requests carry a kind, a row, a column and a value. Kind 0 stores an
// element of A, kind 1 stores an element of B; each gives no result, and
// loads stream at one per cycle while idle. Kind 2 computes C and returns
// one result per element in row-major order, the final one flagged by last.
// Each result element reads its A row and B column one term per cycle through
// a single read port per store and one multiplier; a compute request holds
// the input channel until the last result is emitted. Sums wrap to 32 bits.
// The user must write the dimension registers via the cfg port only while
// idle, unenforced by the block; zero counts as one, over MAX_DIM as MAX_DIM.
// Results sit in an output register. When the receiver stalls the sequence
// pauses until that register is free, and loads are taken while the last
// result still waits. Reset empties the output, returns the controller to
// idle and sets each dimension to 8; the element stores hold no defined
// contents until written.
// ----------------------------------------------------------------------------
module integer_matrix_multiply
  import imm_pkg::*;
#(
  parameter int MAX_DIM = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [3:0]         cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         kind,
  input  wire logic [2:0]         row_index,
  input  wire logic [2:0]         col_index,
  input  wire logic signed [31:0] elem_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_row,
  output logic [2:0]              out_col,
  output logic signed [31:0]      product_value,
  output logic                    last
);

  imm_cmd_t    cmd;
  imm_status_t status;

  imm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .status   (status),
    .cmd      (cmd)
  );

  imm_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .row_index     (row_index),
    .col_index     (col_index),
    .elem_value    (elem_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_row       (out_row),
    .out_col       (out_col),
    .product_value (product_value),
    .last          (last)
  );

endmodule
`default_nettype wire

>>> hw/rtl/imm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Integer matrix multiply port checker
// Watches the top-level ports for request and result ordering rules.
// ----------------------------------------------------------------------------
module imm_checker
  import imm_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic [1:0]         kind,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [31:0] product_value,
  input wire logic               last
);

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("Outputs not cleared after reset.");

  a_compute_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (kind == KIND_COMPUTE) |=> !in_ready)
    else $error("Input still ready after a compute request.");

  a_busy_until_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("Input ready while results remain.");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(product_value) && $stable(last))
    else $error("Stalled result changed.");

endmodule

bind integer_matrix_multiply imm_checker u_imm_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .kind          (kind),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .product_value (product_value),
  .last          (last)
);
`default_nettype wire
